FILE: rtl/core/fbc_pkg.sv
// ----------------------------------------------------------------------------
// Frustum box culling package
// Shared constants, state encoding and controller command types.
// ----------------------------------------------------------------------------
package fbc_pkg;

   // Default datapath width of one coordinate (Q16.16 at 32 bits).
   localparam int COORD_WIDTH_DEFAULT = 32;

   // Fraction bits of the fixed-point format; the distance is scaled by this.
   localparam int FRAC_BITS = 16;

   // Six planes: left, right, bottom, top, near, far. Four coefficients each.
   localparam int NUM_PLANES  = 6;
   localparam int NUM_COEFS   = 4;
   localparam int NUM_AXES    = 3;
   localparam int PLANE_IDX_W = $clog2(NUM_PLANES);
   localparam logic [PLANE_IDX_W-1:0] LAST_PLANE = PLANE_IDX_W'(NUM_PLANES - 1);

   // Coefficient slot that holds the plane distance.
   localparam logic [1:0] COEF_DIST = 2'd3;

   // Transaction kinds on the request channel.
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_BOX  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                   load;       // write one matrix column into the planes
      logic                   start;      // capture box corners, clear the cull flag
      logic                   issue;      // multiply the selected plane
      logic [PLANE_IDX_W-1:0] plane;      // plane being multiplied
      logic                   accumulate; // sum the registered products, test sign
      logic                   out_load;   // move the verdict into the output register
   } cmd_type;

   // Request payload as the datapath sees it.
   typedef struct packed {
      logic [1:0]         column;
      logic signed [31:0] row0;
      logic signed [31:0] row1;
      logic signed [31:0] row2;
      logic signed [31:0] row3;
      logic signed [31:0] min_x;
      logic signed [31:0] min_y;
      logic signed [31:0] min_z;
      logic signed [31:0] max_x;
      logic signed [31:0] max_y;
      logic signed [31:0] max_z;
   } req_data_type;

endpackage

FILE: rtl/core/fbc_intf.sv
// ----------------------------------------------------------------------------
// Frustum box culling channel interfaces
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface fbc_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [1:0]         column;
   logic signed [31:0] row0;
   logic signed [31:0] row1;
   logic signed [31:0] row2;
   logic signed [31:0] row3;
   logic signed [31:0] min_x;
   logic signed [31:0] min_y;
   logic signed [31:0] min_z;
   logic signed [31:0] max_x;
   logic signed [31:0] max_y;
   logic signed [31:0] max_z;

   modport source (
      output valid, kind, column, row0, row1, row2, row3,
             min_x, min_y, min_z, max_x, max_y, max_z,
      input  ready
   );
   modport sink (
      input  valid, kind, column, row0, row1, row2, row3,
             min_x, min_y, min_z, max_x, max_y, max_z,
      output ready
   );
endinterface

interface fbc_rsp_if;
   logic valid;
   logic ready;
   logic visible;

   modport source (output valid, visible, input ready);
   modport sink (input valid, visible, output ready);
endinterface

FILE: rtl/core/frustum_box_culling_top.sv
// ----------------------------------------------------------------------------
// Frustum box culling top level
// View-frustum culling of axis-aligned boxes by the positive-vertex test.
// ----------------------------------------------------------------------------
// The block holds six frustum planes (left, right, bottom, top, near, far),
// all zero after reset, so every box is visible until a matrix is loaded.
// A load transaction (kind 0) writes one column of the column-major
// projection-view matrix at the edge that accepts it and gives no response; the
// four columns may be loaded in any order, and columns not reloaded keep
// their earlier values. A box transaction (kind 1) produces exactly one
// response whose visible bit is 0 when the box lies fully behind any plane.
// Planes are not normalized, which never changes the sign of the test, and
// the dot product is formed exactly with no rounding or overflow. A box's
// corners are captured at the clock edge that accepts it. The three shared
// multipliers then work on the six planes in turn, the products of the last
// plane are summed, and the verdict is loaded into the output register,
// from which the response is offered. The request side is ready again as
// soon as that output register is loaded, even if the response has not yet
// been taken, so a new transaction can be accepted while the previous
// verdict waits; a new box is not accepted before the verdict of the last
// one is loaded. If the previous verdict is still waiting when the next one
// is complete, the output register load holds off until it is taken.
module frustum_box_culling_top #(
   parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   fbc_req_if.sink   req_if,
   fbc_rsp_if.source rsp_if
);

   fbc_pkg::cmd_type      cmd;
   fbc_pkg::req_data_type req_data;

   // Gather the request payload that the datapath consumes.
   assign req_data.column = req_if.column;
   assign req_data.row0   = req_if.row0;
   assign req_data.row1   = req_if.row1;
   assign req_data.row2   = req_if.row2;
   assign req_data.row3   = req_if.row3;
   assign req_data.min_x  = req_if.min_x;
   assign req_data.min_y  = req_if.min_y;
   assign req_data.min_z  = req_if.min_z;
   assign req_data.max_x  = req_if.max_x;
   assign req_data.max_y  = req_if.max_y;
   assign req_data.max_z  = req_if.max_z;

   // The controller sequences each box through the planes and owns both
   // handshakes; the datapath only follows its commands.
   fbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_kind  (req_if.kind),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   fbc_datapath #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .visible  (rsp_if.visible)
   );

endmodule

FILE: rtl/core/fbc_ctrl.sv
// ----------------------------------------------------------------------------
// Frustum box culling controller
// Sequences one box through the six planes and owns the response valid.
// ----------------------------------------------------------------------------
module fbc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_kind,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fbc_pkg::cmd_type cmd
);

   fbc_pkg::state_type                  state_ff, state_in;
   logic [fbc_pkg::PLANE_IDX_W-1:0]     plane_ff, plane_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbc_pkg::ST_IDLE;
         plane_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         plane_ff     <= plane_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      plane_in  = plane_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.plane = plane_ff;

      case (state_ff)
         fbc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == fbc_pkg::KIND_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  plane_in  = '0;
                  state_in  = fbc_pkg::ST_RUN;
               end
            end
         end
         fbc_pkg::ST_RUN: begin
            // Products of the previous plane are summed while this one multiplies.
            cmd.issue      = 1'b1;
            cmd.accumulate = (plane_ff != '0);
            if (plane_ff == fbc_pkg::LAST_PLANE) begin
               state_in = fbc_pkg::ST_DRAIN;
            end else begin
               plane_in = plane_ff + 1'b1;
            end
         end
         fbc_pkg::ST_DRAIN: begin
            cmd.accumulate = 1'b1;
            state_in       = fbc_pkg::ST_FINISH;
         end
         fbc_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = fbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fbc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   // A new verdict must never overwrite one that has not been taken.
   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("verdict loaded over a pending response");

   // A box always begins its plane sweep at the first plane.
   a_start_plane0: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff == fbc_pkg::ST_RUN && plane_ff == '0))
      else $error("plane sweep did not start at plane zero");

   // The plane counter never runs past the last plane.
   a_plane_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == fbc_pkg::ST_RUN |-> plane_ff <= fbc_pkg::LAST_PLANE)
      else $error("plane counter out of range");

   // After the last plane is issued its products are summed exactly once.
   a_last_drain: assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && plane_ff == fbc_pkg::LAST_PLANE) |=> cmd.accumulate && !cmd.issue)
      else $error("last plane not drained");
`endif

endmodule

FILE: rtl/core/fbc_datapath.sv
// ----------------------------------------------------------------------------
// Frustum box culling datapath
// Plane storage, corner selection, three multipliers and the sign test.
// ----------------------------------------------------------------------------
module fbc_datapath #(
   parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fbc_pkg::cmd_type      cmd,
   input  fbc_pkg::req_data_type req_data,
   output logic                  visible
);

   localparam int W  = COORD_WIDTH;
   localparam int PW = 2 * W + 1;   // exact product width
   localparam int SW = PW + 2;      // sum of four terms

   // Sign-extend a 32-bit input and wrap it to the datapath width.
   function automatic logic signed [W-1:0] to_coord(input logic signed [31:0] v);
      logic [W+31:0] ext;
      ext = {{W{v[31]}}, v};
      return ext[W-1:0];
   endfunction

   logic signed [W:0]   coef_ff  [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_COEFS];
   logic signed [W:0]   coef_in  [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_COEFS];
   logic signed [W-1:0] row_c    [fbc_pkg::NUM_AXES];
   logic signed [W-1:0] row3_c;
   logic signed [W-1:0] min_ff   [fbc_pkg::NUM_AXES];
   logic signed [W-1:0] max_ff   [fbc_pkg::NUM_AXES];
   logic signed [W-1:0] box_min  [fbc_pkg::NUM_AXES];
   logic signed [W-1:0] box_max  [fbc_pkg::NUM_AXES];
   logic signed [W-1:0] corner   [fbc_pkg::NUM_AXES];
   logic signed [PW-1:0] prod_ff [fbc_pkg::NUM_AXES];
   logic signed [PW-1:0] prod_in [fbc_pkg::NUM_AXES];
   logic signed [PW-1:0] dist_ff, dist_in;
   logic signed [SW-1:0] sum;
   logic                 cull_ff, cull_in;
   logic                 visible_ff, visible_in;

   assign row_c[0] = to_coord(req_data.row0);
   assign row_c[1] = to_coord(req_data.row1);
   assign row_c[2] = to_coord(req_data.row2);
   assign row3_c   = to_coord(req_data.row3);

   assign box_min[0] = to_coord(req_data.min_x);
   assign box_min[1] = to_coord(req_data.min_y);
   assign box_min[2] = to_coord(req_data.min_z);
   assign box_max[0] = to_coord(req_data.max_x);
   assign box_max[1] = to_coord(req_data.max_y);
   assign box_max[2] = to_coord(req_data.max_z);

   // Column load: the even plane of each pair gets row3 + row k, the odd one row3 - row k.
   always_comb begin
      coef_in = coef_ff;
      if (cmd.load) begin
         for (int k = 0; k < fbc_pkg::NUM_AXES; k++) begin
            coef_in[2*k][req_data.column]   = {row3_c[W-1], row3_c} + {row_c[k][W-1], row_c[k]};
            coef_in[2*k+1][req_data.column] = {row3_c[W-1], row3_c} - {row_c[k][W-1], row_c[k]};
         end
      end
   end

   // Positive vertex: max where the normal coefficient is non-negative, else min.
   always_comb begin
      for (int a = 0; a < fbc_pkg::NUM_AXES; a++) begin
         corner[a]  = coef_ff[cmd.plane][a][W] ? min_ff[a] : max_ff[a];
         prod_in[a] = PW'(coef_ff[cmd.plane][a]) * PW'(corner[a]);
      end
      dist_in = PW'(coef_ff[cmd.plane][fbc_pkg::COEF_DIST]) <<< fbc_pkg::FRAC_BITS;
   end

   assign sum = SW'(dist_ff) + SW'(prod_ff[0]) + SW'(prod_ff[1]) + SW'(prod_ff[2]);

   always_comb begin
      cull_in = cull_ff;
      if (cmd.start) begin
         cull_in = 1'b0;
      end else if (cmd.accumulate && sum[SW-1]) begin
         cull_in = 1'b1;
      end
      visible_in = cmd.out_load ? !cull_ff : visible_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
            for (int c = 0; c < fbc_pkg::NUM_COEFS; c++) begin
               coef_ff[p][c] <= '0;
            end
         end
         cull_ff <= 1'b0;
      end else begin
         coef_ff <= coef_in;
         cull_ff <= cull_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         min_ff <= box_min;
         max_ff <= box_max;
      end
      if (cmd.issue) begin
         prod_ff <= prod_in;
         dist_ff <= dist_in;
      end
      visible_ff <= visible_in;
   end

   assign visible = visible_ff;

endmodule

FILE: tb/frustum_box_culling_checker.sv
// ----------------------------------------------------------------------------
// Frustum box culling checker
// Watches both channels, keeps its own copy of the six frustum planes and
// compares each visibility verdict with the predicted one, oldest first.
// ----------------------------------------------------------------------------
module frustum_box_culling_checker (
   input  logic clock,
   input  logic reset,
   fbc_req_if   req_ch,
   fbc_rsp_if   rsp_ch,
   output int   pending_verdicts,
   output int   mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [32:0]  coef_type;
   typedef logic signed [127:0] wide_type;

   coef_type plane_coef [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_COEFS];
   bit       visible_fifo [$];
   int       errors = 0;

   function automatic wide_type widen_coef(coef_type v);
      return {{95{v[32]}}, v};
   endfunction

   function automatic wide_type widen_coord(logic [31:0] v);
      return {{96{v[31]}}, v};
   endfunction

   // Positive-vertex test against all six planes, summed exactly in Q96.32.
   function automatic bit predict_visibility(logic [2:0][31:0] lo, logic [2:0][31:0] hi);
      wide_type acc;
      bit       seen;
      seen = 1'b1;
      for (int p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
         acc = widen_coef(plane_coef[p][fbc_pkg::COEF_DIST]) <<< fbc_pkg::FRAC_BITS;
         for (int a = 0; a < fbc_pkg::NUM_AXES; a++) begin
            acc = acc + widen_coef(plane_coef[p][a])
                        * widen_coord(plane_coef[p][a][32] ? lo[a] : hi[a]);
         end
         if (acc[127]) begin
            seen = 1'b0;
         end
      end
      return seen;
   endfunction

   always @(posedge clock) begin : watch
      logic [2:0][31:0] rows;
      logic [2:0][31:0] lo;
      logic [2:0][31:0] hi;
      logic [31:0]      base;
      bit               want;
      if (reset) begin
         for (int p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
            for (int c = 0; c < fbc_pkg::NUM_COEFS; c++) begin
               plane_coef[p][c] = '0;
            end
         end
         visible_fifo.delete();
      end else begin
         // The response is handled first: a verdict leaving at this edge can
         // never belong to a box entering at the same edge.
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (visible_fifo.size() == 0) begin
               $display("%0t: unexpected verdict, expected none, actual %0b",
                        $time, rsp_ch.visible);
               errors++;
            end else begin
               want = visible_fifo.pop_front();
               if (rsp_ch.visible !== want) begin
                  $display("%0t: visible mismatch, expected %0b, actual %0b",
                           $time, want, rsp_ch.visible);
                  errors++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.kind == fbc_pkg::KIND_LOAD) begin
               rows = {req_ch.row2, req_ch.row1, req_ch.row0};
               base = req_ch.row3;
               for (int k = 0; k < fbc_pkg::NUM_AXES; k++) begin
                  plane_coef[2*k][req_ch.column]   = {base[31], base} + {rows[k][31], rows[k]};
                  plane_coef[2*k+1][req_ch.column] = {base[31], base} - {rows[k][31], rows[k]};
               end
            end else begin
               lo = {req_ch.min_z, req_ch.min_y, req_ch.min_x};
               hi = {req_ch.max_z, req_ch.max_y, req_ch.max_x};
               visible_fifo.push_back(predict_visibility(lo, hi));
            end
         end
      end
      pending_verdicts <= visible_fifo.size();
      mismatch_count   <= errors;
   end

endmodule

FILE: tb/frustum_box_culling_top_tb.sv
// ----------------------------------------------------------------------------
// Frustum box culling testbench
// Drives matrix loads and box queries into the culling block with random
// gaps and response stalls; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module frustum_box_culling_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 1050;
   localparam int Q_ONE       = 1 << fbc_pkg::FRAC_BITS;
   localparam int MAX_COORD   = 32'h7fffffff;
   localparam int MIN_COORD   = 32'h80000000;
   // The tail wait after the last verdict allows comfortably for a box to
   // reach its verdict and for a load to finish.
   localparam int TAIL_CYCLES = 16;
   // The limit is far beyond the slowest honest run.
   localparam int LIMIT_NS    = 4_000_000;

   logic clock = 1'b0;
   logic reset;
   int   pending_verdicts;
   int   mismatch_count;
   int   sent_items = 0;
   bit   drained_mid = 1'b0;

   fbc_req_if req_if ();
   fbc_rsp_if rsp_if ();

   frustum_box_culling_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   frustum_box_culling_checker verdict_checker (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_if),
      .rsp_ch           (rsp_if),
      .pending_verdicts (pending_verdicts),
      .mismatch_count   (mismatch_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A stretch of the random part runs with neither side ever idling, so the
   // block is also seen at its full back-to-back rate.
   function automatic bit steady_stretch();
      return sent_items >= 300 && sent_items < 450;
   endfunction

   function automatic int spread(int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   // Every field gets random content; the caller then overwrites the fields
   // that matter for the transaction kind. This also toggles the fields that
   // the block ignores for that kind.
   function automatic fbc_pkg::req_data_type noise_payload();
      fbc_pkg::req_data_type d;
      d.column = 2'($urandom);
      d.row0   = $urandom;
      d.row1   = $urandom;
      d.row2   = $urandom;
      d.row3   = $urandom;
      d.min_x  = $urandom;
      d.min_y  = $urandom;
      d.min_z  = $urandom;
      d.max_x  = $urandom;
      d.max_y  = $urandom;
      d.max_z  = $urandom;
      return d;
   endfunction

   // Offers one transaction and returns at the edge where it is accepted.
   // Valid stays high into the next transaction unless a random gap is taken,
   // so it is never lowered and raised within one time step.
   task automatic offer_request(input logic kind, input fbc_pkg::req_data_type d);
      while (!steady_stretch() && $urandom_range(0, 99) < 11) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.kind   <= kind;
      req_if.column <= d.column;
      req_if.row0   <= d.row0;
      req_if.row1   <= d.row1;
      req_if.row2   <= d.row2;
      req_if.row3   <= d.row3;
      req_if.min_x  <= d.min_x;
      req_if.min_y  <= d.min_y;
      req_if.min_z  <= d.min_z;
      req_if.max_x  <= d.max_x;
      req_if.max_y  <= d.max_y;
      req_if.max_z  <= d.max_z;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      sent_items++;
   endtask

   task automatic send_load(input logic [1:0] col, input int r0, input int r1,
                            input int r2, input int r3);
      fbc_pkg::req_data_type d;
      d        = noise_payload();
      d.column = col;
      d.row0   = r0;
      d.row1   = r1;
      d.row2   = r2;
      d.row3   = r3;
      offer_request(fbc_pkg::KIND_LOAD, d);
   endtask

   task automatic send_box(input int lx, input int ly, input int lz,
                           input int hx, input int hy, input int hz);
      fbc_pkg::req_data_type d;
      d       = noise_payload();
      d.min_x = lx;
      d.min_y = ly;
      d.min_z = lz;
      d.max_x = hx;
      d.max_y = hy;
      d.max_z = hz;
      offer_request(fbc_pkg::KIND_BOX, d);
   endtask

   // Loads a whole matrix, starting at a random column so that every load
   // order pattern of a rotation is exercised.
   task automatic load_matrix(input int m [4][4]);
      int first;
      int c;
      first = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) begin
         c = (first + i) % 4;
         send_load(2'(c), m[0][c], m[1][c], m[2][c], m[3][c]);
      end
   endtask

   // Stops offering and waits until every verdict in flight has been taken.
   // The first edge lets the checker count a box accepted just before.
   task automatic wait_for_verdicts();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts != 0) begin
         @(posedge clock);
      end
   endtask

   // A plausible view: each clip row scales one axis and offsets it, with row
   // 3 close to (0, 0, 0, 1). The frustum is then a box of half-width around
   // 0.5 to 4, and boxes scattered around the origin land inside, across the
   // boundary and outside. A few boxes come with their corners swapped.
   task automatic frustum_scene();
      int m [4][4];
      int cx, cy, cz, hx, hy, hz;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            m[r][c] = spread(2048);
         end
      end
      for (int k = 0; k < 3; k++) begin
         m[k][k] = int'($urandom_range(Q_ONE / 4, 2 * Q_ONE));
         m[k][3] = spread(Q_ONE / 2);
      end
      m[3][3] = Q_ONE + spread(Q_ONE / 16);
      load_matrix(m);
      repeat ($urandom_range(6, 15)) begin
         cx = spread(3 * Q_ONE);
         cy = spread(3 * Q_ONE);
         cz = spread(3 * Q_ONE);
         hx = $urandom_range(0, 3 * Q_ONE / 2);
         hy = $urandom_range(0, 3 * Q_ONE / 2);
         hz = $urandom_range(0, 3 * Q_ONE / 2);
         if ($urandom_range(0, 9) == 0) begin
            send_box(cx + hx, cy + hy, cz + hz, cx - hx, cy - hy, cz - hz);
         end else begin
            send_box(cx - hx, cy - hy, cz - hz, cx + hx, cy + hy, cz + hz);
         end
      end
   endtask

   // Full-range matrix and corners: every bit of every field toggles, and the
   // exact wide sum is pushed to its limits.
   task automatic wild_scene();
      int m [4][4];
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            m[r][c] = $urandom;
         end
      end
      load_matrix(m);
      repeat ($urandom_range(3, 8)) begin
         send_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   // Moderate magnitudes where rounding or truncation in the sum would show.
   task automatic medium_scene();
      int m [4][4];
      int cx, cy, cz, hx, hy, hz;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            m[r][c] = spread(1 << 20);
         end
      end
      load_matrix(m);
      repeat ($urandom_range(4, 10)) begin
         cx = spread(1 << 20);
         cy = spread(1 << 20);
         cz = spread(1 << 20);
         hx = $urandom_range(0, 1 << 19);
         hy = $urandom_range(0, 1 << 19);
         hz = $urandom_range(0, 1 << 19);
         send_box(cx - hx, cy - hy, cz - hz, cx + hx, cy + hy, cz + hz);
      end
   endtask

   // A stray partial load over the current planes, then boxes whose corners
   // are drawn independently and so are often swapped.
   task automatic noise_scene();
      send_load(2'($urandom), $urandom, $urandom, $urandom, $urandom);
      repeat ($urandom_range(1, 4)) begin
         send_box(spread(4 * Q_ONE), spread(4 * Q_ONE), spread(4 * Q_ONE),
                  spread(4 * Q_ONE), spread(4 * Q_ONE), spread(4 * Q_ONE));
      end
   endtask

   // The receiver stalls with a probability of about 11 percent, except during the
   // steady stretch.
   initial begin : response_sink
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= !reset && (steady_stretch() || $urandom_range(0, 99) >= 11);
      end
   end

   initial begin : stimulus
      int pick;
      reset         <= 1'b1;
      req_if.valid  <= 1'b0;
      req_if.kind   <= fbc_pkg::KIND_LOAD;
      req_if.column <= '0;
      req_if.row0   <= '0;
      req_if.row1   <= '0;
      req_if.row2   <= '0;
      req_if.row3   <= '0;
      req_if.min_x  <= '0;
      req_if.min_y  <= '0;
      req_if.min_z  <= '0;
      req_if.max_x  <= '0;
      req_if.max_y  <= '0;
      req_if.max_z  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Before any load every plane is zero, so any box is visible, even one
      // spanning the whole range or with its corners swapped.
      send_box(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE);
      send_box(MAX_COORD, MAX_COORD, MAX_COORD, MIN_COORD, MIN_COORD, MIN_COORD);

      // Partial load: only columns 0 and 3 are written, so all six planes
      // become x - 1 >= 0 while the y and z coefficients stay zero.
      send_load(2'd0, 0, 0, 0, Q_ONE);
      send_load(fbc_pkg::COEF_DIST, 0, 0, 0, -Q_ONE);
      // A sum of exactly zero is still visible; one step less is culled.
      send_box(0, 0, 0, Q_ONE, 0, 0);
      send_box(0, 0, 0, Q_ONE - 1, 0, 0);
      // Swapped corners: the positive normal still takes the max field.
      send_box(5 * Q_ONE, 0, 0, -Q_ONE, 0, 0);
      send_box(MIN_COORD, MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD, MAX_COORD);

      // Extreme matrix elements, giving coefficients at the 33-bit limits.
      send_load(2'd0, MAX_COORD, MIN_COORD, MAX_COORD, MAX_COORD);
      send_load(2'd1, MIN_COORD, MAX_COORD, MIN_COORD, MIN_COORD);
      send_load(2'd2, MAX_COORD, MAX_COORD, MIN_COORD, MAX_COORD);
      send_load(fbc_pkg::COEF_DIST, MIN_COORD, MIN_COORD, MAX_COORD, MIN_COORD);
      send_box(MIN_COORD, MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD, MAX_COORD);
      send_box(MIN_COORD, MIN_COORD, MIN_COORD, MIN_COORD, MIN_COORD, MIN_COORD);
      send_box(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD);
      send_box(MAX_COORD, MAX_COORD, MAX_COORD, MIN_COORD, MIN_COORD, MIN_COORD);

      // All-zero normals: the planes test their distance alone.
      send_load(2'd0, 0, 0, 0, 0);
      send_load(2'd1, 0, 0, 0, 0);
      send_load(2'd2, 0, 0, 0, 0);
      send_load(fbc_pkg::COEF_DIST, 0, 0, 0, -1);
      send_box(MIN_COORD, MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD, MAX_COORD);
      send_load(fbc_pkg::COEF_DIST, 0, 0, 0, 0);
      send_box(MIN_COORD, MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD, MAX_COORD);
      // Left distance +1 but right distance -1: the right plane culls, and so does the bottom one.
      send_load(fbc_pkg::COEF_DIST, Q_ONE, -Q_ONE, 0, 0);
      send_box(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE);

      wait_for_verdicts();

      // Random part, mostly complete matrices followed by box queries.
      while (sent_items < ITEM_TARGET) begin
         if (!drained_mid && sent_items >= ITEM_TARGET / 2) begin
            wait_for_verdicts();
            drained_mid = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            frustum_scene();
         end else if (pick < 75) begin
            wild_scene();
         end else if (pick < 85) begin
            medium_scene();
         end else begin
            noise_scene();
         end
      end

      wait_for_verdicts();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // A hang anywhere ends the run as a failure.
   initial begin : watchdog
      #LIMIT_NS;
      $display("FAIL");
      $finish;
   end

endmodule
